// ----- rtl/mgac_pkg.sv -----
// shared types, constants and the divide-by-five helper for the motion and gas alarm block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mgac_pkg;

    localparam int NOW_W      = 32;
    localparam int SAMPLE_W   = 10;
    localparam int SUM_W      = 13;
    localparam int LEVEL_W    = 10;
    localparam int THR_W      = 10;
    localparam int TIME_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reciprocal of five in 16 fractional bits, exact for sums up to 5115
    localparam int DIV5_SHIFT = 16;
    localparam logic [15:0] DIV5_MUL = 16'd13108;

    localparam logic [THR_W-1:0]  GAS_LIMIT_RESET     = 10'd400;
    localparam logic [TIME_W-1:0] MOTION_ALERT_RESET  = 16'd2000;
    localparam logic [TIME_W-1:0] MOTION_COOL_RESET   = 16'd15000;
    localparam logic [TIME_W-1:0] GAS_HOLD_RESET      = 16'd8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAS_LIMIT       = 2'd0,
        CFG_MOTION_ALERT    = 2'd1,
        CFG_MOTION_COOLDOWN = 2'd2,
        CFG_GAS_HOLD        = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SCREEN_MAIN   = 2'd0,
        SCREEN_MOTION = 2'd1,
        SCREEN_GAS    = 2'd2
    } screen_t;

    typedef enum logic [2:0] {
        MS_IDLE  = 3'b001,
        MS_ALERT = 3'b010,
        MS_COOL  = 3'b100
    } motion_state_t;

    typedef struct packed {
        logic [THR_W-1:0]  gas_limit;
        logic [TIME_W-1:0] motion_alert_ms;
        logic [TIME_W-1:0] motion_cooldown_ms;
        logic [TIME_W-1:0] gas_hold_ms;
    } cfg_t;

    typedef struct packed {
        motion_state_t    mstate;
        logic [NOW_W-1:0] alert_start;
        logic [NOW_W-1:0] cool_start;
        logic             gas_active;
        logic [NOW_W-1:0] hold_start;
    } alarm_state_t;

    typedef struct packed {
        screen_t            screen_select;
        logic               led_on;
        logic [LEVEL_W-1:0] gas_level;
        logic               motion_alert;
        logic               motion_cooldown;
        logic               gas_alarm;
    } result_t;

    // floor(sum / 5) by multiply and shift
    function automatic logic [LEVEL_W-1:0] div5(input logic [SUM_W-1:0] sum);
        logic [SUM_W+DIV5_SHIFT-1:0] prod;
        prod = {{DIV5_SHIFT{1'b0}}, sum} * {{SUM_W{1'b0}}, DIV5_MUL};
        return prod[DIV5_SHIFT +: LEVEL_W];
    endfunction

endpackage

// ----- rtl/motion_and_gas_alarm_controller.sv -----
// top level of the motion and gas alarm controller: handshake, registers, config
// depends on mgac_pkg and mgac_update
`timescale 1ns / 1ps

// channel   | beat contents                                   | handshake
// ----------+-------------------------------------------------+---------------------
// input     | now_ms, motion, gas_sample_a .. gas_sample_e    | in_valid / in_stall
// output    | screen_select, led_on, gas_level, flags         | out_valid / out_stall
// config    | cfg_index, cfg_data                             | cfg_we, no wait
//
// one beat per clock in and out while out_stall is low; an accepted beat is held in
// the input register, then moves into the result register once that register is free
// the gas level is summed and divided by five before the input register, the
// timer compares and state updates sit between input register and result register
// reset clears state, timers and out_valid and loads the default threshold and times
// a held output stalls the input register, which stalls the input channel in the
// same cycle; no beat is dropped

module motion_and_gas_alarm_controller
    import mgac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [NOW_W-1:0]      now_ms,
    input  logic                  motion,
    input  logic [SAMPLE_W-1:0]   gas_sample_a,
    input  logic [SAMPLE_W-1:0]   gas_sample_b,
    input  logic [SAMPLE_W-1:0]   gas_sample_c,
    input  logic [SAMPLE_W-1:0]   gas_sample_d,
    input  logic [SAMPLE_W-1:0]   gas_sample_e,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            screen_select,
    output logic                  led_on,
    output logic [LEVEL_W-1:0]    gas_level,
    output logic                  motion_alert,
    output logic                  motion_cooldown,
    output logic                  gas_alarm,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg;
    alarm_state_t       state_reg;
    alarm_state_t       state_next;

    // input register
    logic               s1_valid_reg;
    logic [NOW_W-1:0]   s1_now_reg;
    logic               s1_motion_reg;
    logic [LEVEL_W-1:0] s1_level_reg;

    // result register
    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result_next;

    logic               in_accept;
    logic               out_free;
    logic               advance;
    logic [SUM_W-1:0]   sample_sum;
    logic [LEVEL_W-1:0] level_in;

    // result register can load when empty or being taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // average of the five samples, done on the way in
    assign sample_sum = {3'b000, gas_sample_a} + {3'b000, gas_sample_b}
                      + {3'b000, gas_sample_c} + {3'b000, gas_sample_d}
                      + {3'b000, gas_sample_e};
    assign level_in = div5(sample_sum);

    // config registers; write them only while idle, which the block itself does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gas_limit          <= GAS_LIMIT_RESET;
            cfg_reg.motion_alert_ms    <= MOTION_ALERT_RESET;
            cfg_reg.motion_cooldown_ms <= MOTION_COOL_RESET;
            cfg_reg.gas_hold_ms        <= GAS_HOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAS_LIMIT:       cfg_reg.gas_limit          <= cfg_data[THR_W-1:0];
                CFG_MOTION_ALERT:    cfg_reg.motion_alert_ms    <= cfg_data[TIME_W-1:0];
                CFG_MOTION_COOLDOWN: cfg_reg.motion_cooldown_ms <= cfg_data[TIME_W-1:0];
                CFG_GAS_HOLD:        cfg_reg.gas_hold_ms        <= cfg_data[TIME_W-1:0];
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_now_reg    <= now_ms;
            s1_motion_reg <= motion;
            s1_level_reg  <= level_in;
        end
    end

    mgac_update u_update (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .now_ms (s1_now_reg),
        .motion (s1_motion_reg),
        .level  (s1_level_reg),
        .nxt    (state_next),
        .res    (result_next)
    );

    // alarm state moves exactly once per beat, as it enters the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mstate      <= MS_IDLE;
            state_reg.alert_start <= '0;
            state_reg.cool_start  <= '0;
            state_reg.gas_active  <= 1'b0;
            state_reg.hold_start  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign screen_select   = result_reg.screen_select;
    assign led_on          = result_reg.led_on;
    assign gas_level       = result_reg.gas_level;
    assign motion_alert    = result_reg.motion_alert;
    assign motion_cooldown = result_reg.motion_cooldown;
    assign gas_alarm       = result_reg.gas_alarm;

endmodule

// ----- rtl/mgac_update.sv -----
// next-state and result logic for one monitoring pass
// depends on mgac_pkg
`timescale 1ns / 1ps

module mgac_update
    import mgac_pkg::*;
(
    input  alarm_state_t       cur,
    input  cfg_t               cfg,
    input  logic [NOW_W-1:0]   now_ms,
    input  logic               motion,
    input  logic [LEVEL_W-1:0] level,
    output alarm_state_t       nxt,
    output result_t            res
);

    logic [NOW_W-1:0]   el_alert;
    logic [NOW_W-1:0]   el_cool;
    logic [NOW_W-1:0]   el_hold;
    logic               alert_done;
    logic               cool_done;
    logic               hold_done;
    logic               gas_low;
    logic [LEVEL_W+2:0] level_x5;
    logic [LEVEL_W+2:0] thr_x4;

    assign el_alert   = now_ms - cur.alert_start;
    assign el_cool    = now_ms - cur.cool_start;
    assign el_hold    = now_ms - cur.hold_start;
    assign alert_done = el_alert >= {{(NOW_W-TIME_W){1'b0}}, cfg.motion_alert_ms};
    assign cool_done  = el_cool >= {{(NOW_W-TIME_W){1'b0}}, cfg.motion_cooldown_ms};
    assign hold_done  = el_hold >= {{(NOW_W-TIME_W){1'b0}}, cfg.gas_hold_ms};

    // release only below 80 percent of threshold: 5*level < 4*threshold
    assign level_x5 = {3'b000, level} + {1'b0, level, 2'b00};
    assign thr_x4   = {1'b0, cfg.gas_limit, 2'b00};
    assign gas_low  = level_x5 < thr_x4;

    always_comb
    begin
        nxt = cur;

        // motion detector: idle -> alert -> cooldown -> idle; a zero alert or cooldown time skips that state
        unique case (cur.mstate)
            MS_IDLE:
            begin
                if (motion)
                begin
                    nxt.alert_start = now_ms;
                    if (cfg.motion_alert_ms == '0)
                    begin
                        // zero alert time falls straight into cooldown, or to idle if the cooldown time is zero too
                        nxt.cool_start = now_ms;
                        nxt.mstate = (cfg.motion_cooldown_ms == '0) ? MS_IDLE : MS_COOL;
                    end
                    else
                    begin
                        nxt.mstate = MS_ALERT;
                    end
                end
            end
            MS_ALERT:
            begin
                if (alert_done)
                begin
                    nxt.cool_start = now_ms;
                    nxt.mstate = (cfg.motion_cooldown_ms == '0) ? MS_IDLE : MS_COOL;
                end
            end
            MS_COOL:
            begin
                if (cool_done)
                begin
                    nxt.mstate = MS_IDLE;
                end
            end
            default:
            begin
                nxt.mstate = MS_IDLE;
            end
        endcase

        // gas alarm with hold timer
        if (cur.gas_active)
        begin
            if (hold_done)
            begin
                if (gas_low)
                begin
                    nxt.gas_active = 1'b0;
                end
                else
                begin
                    nxt.hold_start = now_ms;
                end
            end
        end
        else if (level >= cfg.gas_limit)
        begin
            // a fresh alarm with zero hold restarts at now too, same result
            nxt.gas_active = 1'b1;
            nxt.hold_start = now_ms;
        end
    end

    always_comb
    begin
        res.gas_level       = level;
        res.motion_alert    = (nxt.mstate == MS_ALERT);
        res.motion_cooldown = (nxt.mstate == MS_COOL);
        res.gas_alarm       = nxt.gas_active;
        if (nxt.gas_active)
        begin
            res.screen_select = SCREEN_GAS;
        end
        else if (nxt.mstate == MS_ALERT)
        begin
            res.screen_select = SCREEN_MOTION;
        end
        else
        begin
            res.screen_select = SCREEN_MAIN;
        end
        res.led_on = nxt.gas_active || (nxt.mstate == MS_ALERT);
    end

endmodule

// ----- rtl/mgac_checker.sv -----
// port-level checks for the motion and gas alarm controller, bound to the top level
// depends on mgac_pkg and motion_and_gas_alarm_controller
`timescale 1ns / 1ps

module mgac_port_checks
    import mgac_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [1:0]            screen_select,
    input logic                  led_on,
    input logic [LEVEL_W-1:0]    gas_level,
    input logic                  motion_alert,
    input logic                  motion_cooldown,
    input logic                  gas_alarm
);

    // a stalled beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // a stalled beat keeps its contents, led_on apart
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(screen_select) && $stable(gas_level)
            && $stable(gas_alarm) && $stable(motion_alert) && $stable(motion_cooldown))
        else $error("output beat changed while stalled");

    // alert and cooldown exclude each other
    a_motion_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(motion_alert && motion_cooldown))
        else $error("motion alert and cooldown both set");

    // screen priority follows the flags
    a_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gas_alarm ? (screen_select == SCREEN_GAS)
            : (motion_alert ? (screen_select == SCREEN_MOTION)
                            : (screen_select == SCREEN_MAIN))))
        else $error("screen select disagrees with alarm flags");

    // led lit exactly on an alert screen
    a_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (led_on == (gas_alarm || motion_alert)))
        else $error("led state disagrees with alarm flags");

endmodule

bind motion_and_gas_alarm_controller mgac_port_checks u_port_checks (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .screen_select   (screen_select),
    .led_on          (led_on),
    .gas_level       (gas_level),
    .motion_alert    (motion_alert),
    .motion_cooldown (motion_cooldown),
    .gas_alarm       (gas_alarm)
);
